>>> design/conv3_pkg.sv
// Shared types, constants and helpers for the 3x3 streaming convolution.
// No dependencies; every module of the block imports this package.
package conv3_pkg;

    // Default geometry limits and queue sizing
    localparam int C3_MAX_WIDTH  = 1024;
    localparam int C3_MAX_HEIGHT = 1024;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // Configuration register map
    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_KERNEL_TOP    = 3'd2,
        REG_KERNEL_MIDDLE = 3'd3,
        REG_KERNEL_BOTTOM = 3'd4
    } cfg_reg_t;

    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd480;
    localparam logic [23:0] RST_KERNEL_ROW   = 24'hFF0001;

    // One interior pixel's work: the 3x3 window (row-major, top row first)
    // and the position tags that travel with it
    typedef struct packed {
        logic [8:0][7:0] win;
        logic [9:0]      row;
        logic [9:0]      col;
        logic            last;
    } cv_item_t;

    // Signed coefficient j of a packed kernel row (left coefficient in low byte)
    function automatic logic signed [7:0] kernel_coef(input logic [23:0] krow,
                                                      input int unsigned j);
        kernel_coef = signed'(krow[8*j +: 8]);
    endfunction

endpackage

>>> design/conv3_front.sv
// Front end: pixel acceptance, frame counters, line buffer memory and window.
// Depends on conv3_pkg; pushes one item per interior pixel into the queue.
module conv3_front
    import conv3_pkg::*;
#(
    parameter int MAX_WIDTH  = C3_MAX_WIDTH,
    parameter int MAX_HEIGHT = C3_MAX_HEIGHT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        pixel,
    input  logic [10:0]       image_width,
    input  logic [10:0]       image_height,
    input  logic [QCNT_W-1:0] q_count,
    output logic              push_valid,
    output cv_item_t          push_item
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // Frame position of the next pixel
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // Accept stage registers
    logic          a_valid_reg;
    logic [7:0]    a_pix_reg;
    logic [CW-1:0] a_col_reg;
    logic          a_prod_reg;
    logic          a_last_reg;
    logic [9:0]    a_orow_reg;
    logic [9:0]    a_ocol_reg;

    // Line buffers: {row two above, row just above} per column
    logic [15:0]   line_mem [MAX_WIDTH];
    logic [15:0]   rd_reg;
    logic [15:0]   byp_data_reg;
    logic          byp_reg;

    logic [8:0][7:0] win_reg, win_next;

    logic [CW:0]   w_eff;
    logic [RW:0]   h_eff;
    logic [CW-1:0] c_cur;
    logic [RW-1:0] r_cur;
    logic [CW:0]   c_inc;
    logic [RW:0]   r_inc;
    logic          accept;
    logic          produce;
    logic          is_last;
    logic [QCNT_W:0] occ;
    logic [15:0]   line_rd;
    logic [15:0]   wr_data;
    logic          byp_next;

    // Clamp geometry to 3..max
    always_comb
    begin
        if (image_width < 11'd3)
            w_eff = (CW+1)'(3);
        else if (32'(image_width) > 32'(MAX_WIDTH))
            w_eff = (CW+1)'(MAX_WIDTH);
        else
            w_eff = (CW+1)'(image_width);

        if (image_height < 11'd3)
            h_eff = (RW+1)'(3);
        else if (32'(image_height) > 32'(MAX_HEIGHT))
            h_eff = (RW+1)'(MAX_HEIGHT);
        else
            h_eff = (RW+1)'(image_height);
    end

    // Credit check: queue entries plus the item in the accept stage
    assign occ      = {1'b0, q_count} + {{QCNT_W{1'b0}}, a_valid_reg};
    assign in_ready = occ < (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept   = in_valid && in_ready;

    // Classify the incoming pixel and advance the counters
    always_comb
    begin
        c_cur   = ({1'b0, col_reg} >= w_eff) ? '0 : col_reg;
        r_cur   = ({1'b0, row_reg} >= h_eff) ? '0 : row_reg;
        produce = (r_cur >= RW'(2)) && (c_cur >= CW'(2));
        is_last = ({1'b0, r_cur} == h_eff - (RW+1)'(1))
               && ({1'b0, c_cur} == w_eff - (CW+1)'(1));
        c_inc   = {1'b0, c_cur} + (CW+1)'(1);
        r_inc   = {1'b0, r_cur} + (RW+1)'(1);
        col_next = c_cur;
        row_next = r_cur;
        if (c_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
        end
        else
        begin
            col_next = c_inc[CW-1:0];
        end
    end

    // Line data for the item in the accept stage, with forwarding of a
    // write to the same column in the previous cycle
    assign line_rd  = byp_reg ? byp_data_reg : rd_reg;
    assign wr_data  = {line_rd[7:0], a_pix_reg};
    assign byp_next = accept && a_valid_reg && (c_cur == a_col_reg);

    // Shift the window left and load the new right column
    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = line_rd[15:8];
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = line_rd[7:0];
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = a_pix_reg;
    end

    // Line buffer memory: read on accept, write back in the following cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg <= line_mem[c_cur];
        end
        if (a_valid_reg)
        begin
            line_mem[a_col_reg] <= wr_data;
        end
        byp_data_reg <= wr_data;
    end

    // Payload of the accept stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_pix_reg  <= pixel;
            a_col_reg  <= c_cur;
            a_prod_reg <= produce;
            a_last_reg <= is_last;
            a_orow_reg <= 10'(r_cur - RW'(1));
            a_ocol_reg <= 10'(c_cur - CW'(1));
        end
    end

    // Control state: counters, stage valid, window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
            byp_reg     <= 1'b0;
            win_reg     <= '0;
        end
        else
        begin
            a_valid_reg <= accept;
            byp_reg     <= byp_next;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (a_valid_reg)
            begin
                win_reg <= win_next;
            end
        end
    end

    // Hand interior pixels to the queue
    assign push_valid     = a_valid_reg && a_prod_reg;
    assign push_item.win  = win_next;
    assign push_item.row  = a_orow_reg;
    assign push_item.col  = a_ocol_reg;
    assign push_item.last = a_last_reg;

    // An accepted beat always occupies the accept stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> a_valid_reg)
        else $error("accept stage lost a beat");

endmodule

>>> design/conv3_queue.sv
// Short FIFO of window items between the front end and the back end.
// Depends on conv3_pkg for the item type.
module conv3_queue
    import conv3_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  cv_item_t                   push_item,
    input  logic                       pop,
    output logic                       q_valid,
    output cv_item_t                   q_item,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    cv_item_t          store [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CNW-1:0]    count_reg;
    logic              do_push;
    logic              do_pop;

    assign do_push = push;
    assign do_pop  = pop && (count_reg != '0);
    assign q_valid = count_reg != '0;
    assign q_item  = store[rd_ptr_reg];
    assign count   = count_reg;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
                count_reg <= count_reg + CNW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNW'(1);
        end
    end

    // Overflow and underflow checks
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CNW'(DEPTH)))
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

endmodule

>>> design/conv3_back.sv
// Back end: nine kernel products, sum, clamp and the output register.
// Depends on conv3_pkg for the item type and coefficient extraction.
module conv3_back
    import conv3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  cv_item_t    q_item,
    output logic        pop,
    input  logic [23:0] kernel_top,
    input  logic [23:0] kernel_middle,
    input  logic [23:0] kernel_bottom,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  value,
    output logic [9:0]  out_row,
    output logic [9:0]  out_col,
    output logic        last
);

    logic [2:0][23:0]        krows;
    logic signed [16:0]      prod_next [9];
    logic signed [16:0]      prod_reg  [9];
    logic                    s1_valid_reg;
    logic [9:0]              s1_row_reg;
    logic [9:0]              s1_col_reg;
    logic                    s1_last_reg;
    logic                    out_valid_reg;
    logic [7:0]              value_reg;
    logic [9:0]              row_reg;
    logic [9:0]              col_reg;
    logic                    last_reg;
    logic                    out_free;
    logic                    s1_take;
    logic signed [20:0]      rsum [3];
    logic signed [20:0]      total;
    logic [7:0]              clamped;

    assign krows = {kernel_bottom, kernel_middle, kernel_top};

    // Stage handshake: each stage moves when the one after it has room
    assign out_free = !out_valid_reg || out_ready;
    assign s1_take  = !s1_valid_reg || out_free;
    assign pop      = q_valid && s1_take;

    // Products of pixel and coefficient
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_next[i*3+j] = signed'({1'b0, q_item.win[i*3+j]})
                                 * kernel_coef(krows[i], j);
            end
        end
    end

    // Row sums, total and clamp to 0..255
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rsum[i] = 21'(prod_reg[i*3]) + 21'(prod_reg[i*3+1]) + 21'(prod_reg[i*3+2]);
        end
        total = rsum[0] + rsum[1] + rsum[2];
        if (total < 0)
            clamped = 8'd0;
        else if (total > 21'sd255)
            clamped = 8'd255;
        else
            clamped = total[7:0];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int k = 0; k < 9; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
            s1_row_reg  <= q_item.row;
            s1_col_reg  <= q_item.col;
            s1_last_reg <= q_item.last;
        end
        if (s1_valid_reg && out_free)
        begin
            value_reg <= clamped;
            row_reg   <= s1_row_reg;
            col_reg   <= s1_col_reg;
            last_reg  <= s1_last_reg;
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_take)
            begin
                s1_valid_reg <= pop;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign out_row   = row_reg;
    assign out_col   = col_reg;
    assign last      = last_reg;

    // A popped item always lands in the product stage
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> s1_valid_reg)
        else $error("popped item dropped");

endmodule

>>> design/conv3x3_clamped_stream_unit.sv
// Top level of the 3x3 streaming convolution with clamped results.
// Depends on conv3_pkg, conv3_front, conv3_queue and conv3_back.
//
// Pixels enter in raster order, one beat per clock while the queue has
// room; the line buffer memory is read and written once per cycle, which
// sets that rate. Each interior pixel yields one result beat (kernel sum
// clamped to 0..255 with its row and column) once its neighbourhood is
// complete, via the accept stage, queue, product stage and output
// register; border pixels yield none. A four-entry queue decouples pixel
// intake from the arithmetic, so intake continues while the output is
// stalled until the queue fills. Line buffers need no clearing after
// reset. Write the geometry and kernel registers only while idle.
module conv3x3_clamped_stream_unit
    import conv3_pkg::*;
#(
    parameter int MAX_WIDTH  = C3_MAX_WIDTH,
    parameter int MAX_HEIGHT = C3_MAX_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pixel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  value,
    output logic [9:0]  out_row,
    output logic [9:0]  out_col,
    output logic        last
);

    logic [10:0]       image_width_reg;
    logic [10:0]       image_height_reg;
    logic [23:0]       kernel_top_reg;
    logic [23:0]       kernel_middle_reg;
    logic [23:0]       kernel_bottom_reg;

    logic              push_valid;
    cv_item_t          push_item;
    logic              pop;
    logic              q_valid;
    cv_item_t          q_item;
    logic [QCNT_W-1:0] q_count;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= RST_IMAGE_WIDTH;
            image_height_reg  <= RST_IMAGE_HEIGHT;
            kernel_top_reg    <= RST_KERNEL_ROW;
            kernel_middle_reg <= RST_KERNEL_ROW;
            kernel_bottom_reg <= RST_KERNEL_ROW;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[10:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[10:0];
                REG_KERNEL_TOP:    kernel_top_reg    <= cfg_data;
                REG_KERNEL_MIDDLE: kernel_middle_reg <= cfg_data;
                REG_KERNEL_BOTTOM: kernel_bottom_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    conv3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel        (pixel),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .q_count      (q_count),
        .push_valid   (push_valid),
        .push_item    (push_item)
    );

    conv3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_item (push_item),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .count     (q_count)
    );

    conv3_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .pop           (pop),
        .kernel_top    (kernel_top_reg),
        .kernel_middle (kernel_middle_reg),
        .kernel_bottom (kernel_bottom_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .value         (value),
        .out_row       (out_row),
        .out_col       (out_col),
        .last          (last)
    );

endmodule
